// ===== rtl/insort_pkg.sv =====
package insort_pkg;

  localparam int CAPACITY   = 64;
  localparam int KEY_BITS   = 32;
  localparam int FIELD_BITS = 32;

  typedef logic signed [KEY_BITS-1:0] key_t;

  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_INSERT,
    CMD_SHIFT
  } cell_cmd_t;

  typedef struct packed {
    key_t key;
    logic valid;
    logic gt;
  } cell_link_t;

  function automatic key_t to_key(input logic [FIELD_BITS-1:0] f);
    logic [63:0] w;
    begin
      w = 64'(f);
      return key_t'(w[KEY_BITS-1:0]);
    end
  endfunction

  function automatic logic [FIELD_BITS-1:0] from_key(input key_t k);
    logic [63:0] w;
    begin
      w = 64'(unsigned'(k));
      return w[FIELD_BITS-1:0];
    end
  endfunction

endpackage

// ===== rtl/insort_cell.sv =====
module insort_cell (
  input  logic                   clk,
  input  logic                   rst_n,
  input  insort_pkg::cell_cmd_t  cmd,
  input  insort_pkg::key_t       new_key,
  input  insort_pkg::cell_link_t left,
  input  insort_pkg::cell_link_t right,
  output insort_pkg::cell_link_t link
);
  import insort_pkg::*;

  key_t key_r;
  key_t key_nxt;
  logic valid_r;
  logic valid_nxt;
  logic gt;

  assign gt = !valid_r || (new_key < key_r);

  always_comb begin
    key_nxt   = key_r;
    valid_nxt = valid_r;
    unique case (cmd)
      CMD_INSERT: begin
        if (gt) begin
          key_nxt   = left.gt ? left.key : new_key;
          valid_nxt = valid_r || left.valid;
        end
      end
      CMD_SHIFT: begin
        key_nxt   = right.key;
        valid_nxt = right.valid;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign link.key   = key_r;
  assign link.valid = valid_r;
  assign link.gt    = gt;

endmodule

// ===== rtl/insertion_sorter_top.sv =====
// Insertion sorter for runs of up to 64 signed keys, held in a row of cells ordered
// ascending. While a run loads the block takes one key per cycle: each key is compared
// with every cell at once and the larger keys move up one cell. The beat that carries
// is_last starts emission: in_stall stays high while the n held keys leave through
// cell 0, one per cycle when out_stall is low. Keys that arrive when all cells are
// full are dropped, and overflowed is then set on every result of that run; the final
// result carries final_flag.
module insertion_sorter_top (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [insort_pkg::FIELD_BITS-1:0]  in_key_value,
  input  logic                               in_is_last,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [insort_pkg::FIELD_BITS-1:0]  out_sorted_key,
  output logic                               out_final_flag,
  output logic                               out_overflowed
);
  import insort_pkg::*;

  typedef enum logic {
    S_LOAD,
    S_EMIT
  } state_t;

  state_t     state_r;
  logic       overflow_r;
  logic       out_valid_r;
  logic [FIELD_BITS-1:0] out_key_r;
  logic       out_final_r;
  logic       out_ovf_r;

  cell_cmd_t  cmd;
  key_t       new_key;
  cell_link_t links [CAPACITY];
  cell_link_t lefts [CAPACITY];
  cell_link_t rights [CAPACITY];
  logic       in_take;
  logic       full;
  logic       out_load;
  logic       last_out;

  assign in_stall = (state_r != S_LOAD);
  assign in_take  = in_valid && !in_stall;
  assign full     = links[CAPACITY-1].valid;
  assign new_key  = to_key(in_key_value);
  assign out_load = (state_r == S_EMIT) && (!out_valid_r || !out_stall);
  assign last_out = !links[1].valid;

  always_comb begin
    cmd = CMD_HOLD;
    if (in_take && !full) begin
      cmd = CMD_INSERT;
    end else if (out_load) begin
      cmd = CMD_SHIFT;
    end
  end

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      if (gi == 0) begin : g_first
        assign lefts[gi] = '{key: '0, valid: 1'b1, gt: 1'b0};
      end else begin : g_mid
        assign lefts[gi] = links[gi-1];
      end
      if (gi == CAPACITY - 1) begin : g_end
        assign rights[gi] = '{key: '0, valid: 1'b0, gt: 1'b1};
      end else begin : g_inner
        assign rights[gi] = links[gi+1];
      end
      insort_cell u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .new_key (new_key),
        .left    (lefts[gi]),
        .right   (rights[gi]),
        .link    (links[gi])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_key_r   <= from_key(links[0].key);
      out_final_r <= last_out;
      out_ovf_r   <= overflow_r;
    end
    if (!rst_n) begin
      state_r     <= S_LOAD;
      overflow_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_LOAD: begin
          if (in_take) begin
            if (full) begin
              overflow_r <= 1'b1;
            end
            if (in_is_last) begin
              state_r <= S_EMIT;
            end
          end
        end
        S_EMIT: begin
          if (out_load && last_out) begin
            state_r    <= S_LOAD;
            overflow_r <= 1'b0;
          end
        end
        default: state_r <= S_LOAD;
      endcase
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_sorted_key = out_key_r;
  assign out_final_flag = out_final_r;
  assign out_overflowed = out_ovf_r;

endmodule

// ===== rtl/insort_chk.sv =====
module insort_chk (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_stall,
  input logic                               in_is_last,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic [insort_pkg::FIELD_BITS-1:0]  out_sorted_key,
  input logic                               out_final_flag
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_sorted_key) && $stable(out_final_flag))
    else $error("A stalled result beat changed.");

  a_last_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_is_last |=> in_stall)
    else $error("Input was not stalled after the last key of a run.");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_stall) |-> $past(in_valid && in_is_last))
    else $error("Input stalled without a last key having been taken.");

  a_load_goes_on: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !in_is_last |=> !in_stall)
    else $error("Input stalled after a key that was not the last of its run.");

endmodule

bind insertion_sorter_top insort_chk u_insort_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .in_is_last     (in_is_last),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_sorted_key (out_sorted_key),
  .out_final_flag (out_final_flag)
);

// ===== bench/insertion_sorter_top_tb.sv =====
`timescale 1ns / 100ps

module insertion_sorter_top_tb;
  import insort_pkg::*;

  typedef struct packed {
    logic [FIELD_BITS-1:0] key;
    logic                  last;
    logic                  typed;
    logic [FIELD_BITS-1:0] want;
  } stim_row_t;

  typedef struct packed {
    key_t key;
    logic fin;
    logic ovf;
  } sorted_beat_t;

  localparam int PLAN_ROWS = 21;
  localparam int LONG_HOLD = 400;
  localparam int ITEMS     = 130;

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [FIELD_BITS-1:0] in_key_value = '0;
  logic                  in_is_last = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [FIELD_BITS-1:0] out_sorted_key;
  logic                  out_final_flag;
  logic                  out_overflowed;

  key_t         held_keys [CAPACITY];
  int           held_n = 0;
  bit           dropped_any = 1'b0;
  sorted_beat_t sorted_q [$];
  int           fails = 0;
  int           sent = 0;
  bit           steady = 1'b0;
  bit           long_hold_done = 1'b0;

  // Single-key runs straight after reset carry their result in the table.
  stim_row_t plan [PLAN_ROWS] = '{
    '{32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000},
    '{32'h7FFF_FFFF, 1'b1, 1'b1, 32'h7FFF_FFFF},
    '{32'h8000_0000, 1'b1, 1'b1, 32'h8000_0000},
    '{32'hFFFF_FFFF, 1'b1, 1'b1, 32'hFFFF_FFFF},
    '{32'h0000_0001, 1'b1, 1'b1, 32'h0000_0001},
    '{32'h0000_0005, 1'b0, 1'b0, 32'h0},
    '{32'hFFFF_FFFD, 1'b0, 1'b0, 32'h0},
    '{32'h8000_0000, 1'b0, 1'b0, 32'h0},
    '{32'h7FFF_FFFF, 1'b0, 1'b0, 32'h0},
    '{32'h0000_0005, 1'b0, 1'b0, 32'h0},
    '{32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0},
    '{32'h0000_0000, 1'b0, 1'b0, 32'h0},
    '{32'h8000_0000, 1'b0, 1'b0, 32'h0},
    '{32'hAAAA_AAAA, 1'b0, 1'b0, 32'h0},
    '{32'h5555_5555, 1'b0, 1'b0, 32'h0},
    '{32'h0000_0001, 1'b1, 1'b0, 32'h0},
    '{32'h7FFF_FFFF, 1'b0, 1'b0, 32'h0},
    '{32'h8000_0000, 1'b1, 1'b0, 32'h0},
    '{32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0},
    '{32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0},
    '{32'hFFFF_FFFF, 1'b1, 1'b0, 32'h0}
  };

  insertion_sorter_top uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_key_value  (in_key_value),
    .in_is_last    (in_is_last),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_sorted_key(out_sorted_key),
    .out_final_flag(out_final_flag),
    .out_overflowed(out_overflowed)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("insertion_sorter_top_tb: errors");
    $finish;
  end

  function automatic void insert_key(input logic [FIELD_BITS-1:0] raw, input logic last);
    key_t k;
    int   p;
    k = key_t'(raw);
    if (held_n < CAPACITY) begin
      p = held_n;
      while (p > 0 && k < held_keys[p-1]) begin
        held_keys[p] = held_keys[p-1];
        p--;
      end
      held_keys[p] = k;
      held_n++;
    end else begin
      dropped_any = 1'b1;
    end
    if (last) begin
      for (int i = 0; i < held_n; i++) begin
        sorted_q.push_back('{key: held_keys[i], fin: (i == held_n - 1), ovf: dropped_any});
      end
      held_n = 0;
      dropped_any = 1'b0;
    end
  endfunction

  task automatic offer_key(input logic [FIELD_BITS-1:0] k, input logic last);
    if (!steady && $urandom_range(99) < 24) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_key_value <= k;
    in_is_last   <= last;
    do @(posedge clk); while (in_stall !== 1'b0);
    sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sorted_q.size() != 0) @(posedge clk);
  endtask

  initial begin : sink
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (!long_hold_done && rst_n && out_valid === 1'b1 &&
                   out_overflowed === 1'b1) begin
        long_hold_done = 1'b1;
        hold_left = LONG_HOLD;
        out_stall <= 1'b1;
      end else if (steady) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < 24);
      end
    end
  end

  always @(posedge clk) begin : check_beat
    sorted_beat_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (sorted_q.size() == 0) begin
        $error("sorted_key: expected none, got %0d", $signed(out_sorted_key));
        fails++;
      end else begin
        want = sorted_q.pop_front();
        if (out_sorted_key !== FIELD_BITS'(want.key)) begin
          $error("sorted_key: expected %0d, got %0d", want.key, $signed(out_sorted_key));
          fails++;
        end
        if (out_final_flag !== want.fin) begin
          $error("final_flag: expected %0b, got %0b", want.fin, out_final_flag);
          fails++;
        end
        if (out_overflowed !== want.ovf) begin
          $error("overflowed: expected %0b, got %0b", want.ovf, out_overflowed);
          fails++;
        end
      end
    end
  end

  initial begin : stimulus
    logic [FIELD_BITS-1:0] k;
    int                    len;
    int                    pick;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[r]) begin
      offer_key(plan[r].key, plan[r].last);
      if (plan[r].typed) begin
        sorted_q.push_back('{key: key_t'(plan[r].want), fin: 1'b1, ovf: 1'b0});
      end else begin
        insert_key(plan[r].key, plan[r].last);
      end
    end
    drain_results();

    // Overfill the store with no idling; the key marked last is itself dropped.
    steady = 1'b1;
    for (int j = 1; j <= CAPACITY + 2; j++) begin
      k = $urandom;
      offer_key(k, j == CAPACITY + 2);
      insert_key(k, j == CAPACITY + 2);
    end
    steady = 1'b0;

    while (sent < ITEMS) begin
      pick = $urandom_range(99);
      if (pick < 65) begin
        len = $urandom_range(1, 8);
      end else if (pick < 90) begin
        len = $urandom_range(9, 40);
      end else begin
        len = $urandom_range(CAPACITY - 2, CAPACITY + 3);
      end
      if (len > ITEMS - sent) begin
        len = ITEMS - sent;
      end
      for (int j = 1; j <= len; j++) begin
        case ($urandom_range(3))
          0: k = 32'($urandom_range(6)) - 32'd3;
          1: k = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
          default: k = $urandom;
        endcase
        offer_key(k, j == len);
        insert_key(k, j == len);
      end
      if ($urandom_range(9) == 0) begin
        drain_results();
      end
    end

    drain_results();
    repeat (20) @(posedge clk);
    if (fails == 0) begin
      $display("insertion_sorter_top_tb: clean");
    end else begin
      $display("insertion_sorter_top_tb: errors");
    end
    $finish;
  end

endmodule
